[src/tpq_pkg.sv]
`timescale 1ns / 1ps

package tpq_pkg;

  // operation codes; the unused code behaves as a peek
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_SERVE = 2'd1;
  localparam logic [1:0] FUNC_PEEK  = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

  // input item
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] entry_tag;
    logic [1:0]  entry_level;
  } req_t;

  // result item
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_tag;
    logic [1:0]  out_level;
  } rsp_t;

  // command broadcast to every level cell
  typedef struct packed {
    logic       exec;
    logic [1:0] func;
    logic [1:0] level;
  } cell_ctrl_t;

  // data handed from one level cell to the next, most urgent first
  typedef struct packed {
    logic        claimed;
    logic        add_ok;
    logic [15:0] tag;
    logic [1:0]  level;
  } chain_t;

endpackage

[src/tpq_ram.sv]
`timescale 1ns / 1ps

module tpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/tpq_cell.sv]
`timescale 1ns / 1ps

module tpq_cell #(
  parameter int LEVEL             = 0,
  parameter int ENTRIES_PER_LEVEL = 16,
  parameter int TAG_BITS          = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tpq_pkg::cell_ctrl_t    ctrl,
  input  logic [TAG_BITS-1:0]    wr_tag,
  input  tpq_pkg::chain_t        chain_in,
  output tpq_pkg::chain_t        chain_out
);

  localparam int PTR_W = $clog2(ENTRIES_PER_LEVEL);
  localparam int CNT_W = $clog2(ENTRIES_PER_LEVEL + 1);

  logic [PTR_W-1:0]    head, head_next;
  logic [PTR_W-1:0]    tail, tail_next;
  logic [CNT_W-1:0]    count, count_next;
  logic                owner, owner_next;
  logic                nonempty;
  logic                full;
  logic                addressed;
  logic                is_add;
  logic                do_add;
  logic                win;
  logic [TAG_BITS-1:0] rd_tag;
  logic [15:0]         rd_tag16;

  // decode this level's part of the command
  assign nonempty  = (count != '0);
  assign full      = (count == CNT_W'(ENTRIES_PER_LEVEL));
  assign addressed = (32'(ctrl.level) == LEVEL);
  assign is_add    = (ctrl.func == tpq_pkg::FUNC_ADD);
  assign do_add    = ctrl.exec && is_add && addressed && !full;
  assign win       = ctrl.exec && !is_add && !chain_in.claimed && nonempty;

  // pointer and count updates
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    owner_next = owner;
    if (do_add) begin
      tail_next  = (tail == PTR_W'(ENTRIES_PER_LEVEL - 1)) ? '0 : tail + 1'b1;
      count_next = count + 1'b1;
    end
    if (ctrl.exec) begin
      owner_next = win;
    end
    if (win && ctrl.func == tpq_pkg::FUNC_SERVE) begin
      head_next  = (head == PTR_W'(ENTRIES_PER_LEVEL - 1)) ? '0 : head + 1'b1;
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      owner <= 1'b0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      owner <= owner_next;
    end
  end

  // tag store of this level
  tpq_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (ENTRIES_PER_LEVEL)
  ) u_ram (
    .clk   (clk),
    .we    (do_add),
    .waddr (tail),
    .wdata (wr_tag),
    .re    (win),
    .raddr (head),
    .rdata (rd_tag)
  );

  // shown tag is the low 16 bits
  generate
    if (TAG_BITS == 16) begin : g_tag_eq
      assign rd_tag16 = rd_tag;
    end else if (TAG_BITS > 16) begin : g_tag_wide
      assign rd_tag16 = rd_tag[15:0];
    end else begin : g_tag_narrow
      assign rd_tag16 = {{(16 - TAG_BITS){1'b0}}, rd_tag};
    end
  endgenerate

  // pass claim, add outcome and read data down the chain
  always_comb begin
    chain_out.claimed = chain_in.claimed || nonempty;
    chain_out.add_ok  = chain_in.add_ok || (addressed && !full);
    chain_out.tag     = owner ? rd_tag16 : chain_in.tag;
    chain_out.level   = owner ? 2'(LEVEL) : chain_in.level;
  end

endmodule

[src/three_level_priority_queue_unit.sv]
`timescale 1ns / 1ps

// Priority queue with NUM_LEVELS FIFO levels of ENTRIES_PER_LEVEL entries,
// level 0 most urgent. An item is taken when start is high and busy is low;
// every item gives exactly one result, shown on rsp for one cycle with done
// high, which the receiver must take at once. An add, and a serve or peek
// on an empty queue, goes from ST_EXEC straight back to ST_IDLE with the
// result strobe; a serve or peek that finds an entry passes through ST_READ
// as well, for the registered read of the level's tag memory. Each level
// is one cell of a chain that resolves which level is served. The tag
// memories need no clearing after reset.
module three_level_priority_queue_unit #(
  parameter int ENTRIES_PER_LEVEL = 16,
  parameter int NUM_LEVELS        = 3,
  parameter int TAG_BITS          = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tpq_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output tpq_pkg::rsp_t rsp
);

  tpq_pkg::state_t     state, state_next;
  tpq_pkg::req_t       req_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [TAG_BITS-1:0] tag_in;
  logic [15:0]         tag_echo;
  logic                done_next;
  tpq_pkg::rsp_t       rsp_next;
  tpq_pkg::cell_ctrl_t ctrl;
  tpq_pkg::chain_t     chain [NUM_LEVELS+1];
  logic                accept;

  assign busy   = (state != tpq_pkg::ST_IDLE);
  assign accept = start && !busy;

  // keep the tag to TAG_BITS bits
  generate
    if (TAG_BITS == 16) begin : g_tag_eq
      assign tag_in   = req.entry_tag;
      assign tag_echo = tag_q;
    end else if (TAG_BITS > 16) begin : g_tag_wide
      assign tag_in   = {{(TAG_BITS - 16){1'b0}}, req.entry_tag};
      assign tag_echo = tag_q[15:0];
    end else begin : g_tag_narrow
      assign tag_in   = req.entry_tag[TAG_BITS-1:0];
      assign tag_echo = {{(16 - TAG_BITS){1'b0}}, tag_q};
    end
  endgenerate

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
      tag_q <= tag_in;
    end
  end

  // command to the cells
  always_comb begin
    ctrl.exec  = (state == tpq_pkg::ST_EXEC);
    ctrl.func  = req_q.func;
    ctrl.level = req_q.entry_level;
  end

  // level cells, most urgent first
  assign chain[0] = '0;

  generate
    for (genvar i = 0; i < NUM_LEVELS; i++) begin : g_cell
      tpq_cell #(
        .LEVEL             (i),
        .ENTRIES_PER_LEVEL (ENTRIES_PER_LEVEL),
        .TAG_BITS          (TAG_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .wr_tag    (tag_q),
        .chain_in  (chain[i]),
        .chain_out (chain[i+1])
      );
    end
  endgenerate

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpq_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (done_next) begin
      rsp <= rsp_next;
    end
  end

  // next state and result
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    rsp_next   = '0;
    unique case (state)
      tpq_pkg::ST_IDLE: begin
        if (start) begin
          state_next = tpq_pkg::ST_EXEC;
        end
      end
      tpq_pkg::ST_EXEC: begin
        if (req_q.func == tpq_pkg::FUNC_ADD) begin
          state_next         = tpq_pkg::ST_IDLE;
          done_next          = 1'b1;
          rsp_next.status    = chain[NUM_LEVELS].add_ok ? tpq_pkg::STATUS_OK
                                                         : tpq_pkg::STATUS_FULL;
          rsp_next.out_tag   = tag_echo;
          rsp_next.out_level = req_q.entry_level;
        end else if (!chain[NUM_LEVELS].claimed) begin
          state_next      = tpq_pkg::ST_IDLE;
          done_next       = 1'b1;
          rsp_next.status = tpq_pkg::STATUS_EMPTY;
        end else begin
          state_next = tpq_pkg::ST_READ;
        end
      end
      tpq_pkg::ST_READ: begin
        state_next         = tpq_pkg::ST_IDLE;
        done_next          = 1'b1;
        rsp_next.status    = tpq_pkg::STATUS_OK;
        rsp_next.out_tag   = chain[NUM_LEVELS].tag;
        rsp_next.out_level = chain[NUM_LEVELS].level;
      end
      default: begin
        state_next = tpq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
